>>> src/soa_pkg.sv
`default_nettype none
package soa_pkg;
  localparam int SLAB_SLOTS_DEF = 16;
  localparam int OBJ_MAX_DEF    = 64;

  typedef enum logic [1:0] {
    KIND_UNUSED  = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_PARTIAL = 2'd2,
    KIND_FULL    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOSLAB  = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  localparam logic CFG_OBJS  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PICK,
    S_SCAN,
    S_SET,
    S_FCHK,
    S_FCLR,
    S_FLIST,
    S_SHRINK,
    S_OUT
  } fsm_t;
endpackage
`default_nettype wire

>>> src/soa_in_if.sv
`default_nettype none
interface soa_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [3:0] slab_id;
  logic [5:0] obj_index;
  modport source (output valid, req_type, slab_id, obj_index, input ready);
  modport sink   (input valid, req_type, slab_id, obj_index, output ready);
endinterface
`default_nettype wire

>>> src/soa_out_if.sv
`default_nettype none
interface soa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  alloc_slab;
  logic [5:0]  alloc_index;
  logic [10:0] used_count;
  logic [4:0]  slab_count;
  logic [4:0]  slabs_released;
  modport source (output valid, status, alloc_slab, alloc_index, used_count,
                  slab_count, slabs_released, input ready);
  modport sink   (input valid, status, alloc_slab, alloc_index, used_count,
                  slab_count, slabs_released, output ready);
endinterface
`default_nettype wire

>>> src/soa_bit_scan.sv
`default_nettype none
// Shared bitmap unit: finds the lowest clear bit below a limit, 8 bits a cycle.
module soa_bit_scan #(
  parameter int OBJ_MAX = soa_pkg::OBJ_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [OBJ_MAX-1:0]         word,
  input  wire logic [$clog2(OBJ_MAX+1)-1:0] limit,
  output logic                            done,
  output logic                            found,
  output logic [$clog2(OBJ_MAX)-1:0]      index
);
  import soa_pkg::*;
  localparam int IW  = $clog2(OBJ_MAX);
  localparam int CW  = $clog2(OBJ_MAX+1);
  localparam int CH  = (OBJ_MAX + 7) / 8;
  localparam int PW  = CH * 8;
  localparam int PIW = $clog2(PW);

  logic [PW-1:0] pad;
  logic          busy_r, busy_nxt;
  logic [CW-1:0] base_r, base_nxt;
  logic [7:0]    probe;
  logic          hit;
  logic [2:0]    off;
  logic [CW-1:0] cand;

  assign pad = {{(PW-OBJ_MAX){1'b1}}, word};

  // probe one byte for a clear bit
  always_comb begin
    probe = pad[base_r[PIW-1:0] +: 8];
    hit = 1'b0;
    off = '0;
    for (int k = 7; k >= 0; k--) begin
      if (!probe[k]) begin
        hit = 1'b1;
        off = 3'(k);
      end
    end
    cand = base_r + CW'(off);
  end

  always_comb begin
    busy_nxt = busy_r;
    base_nxt = base_r;
    done  = 1'b0;
    found = 1'b0;
    index = cand[IW-1:0];
    if (start) begin
      busy_nxt = 1'b1;
      base_nxt = '0;
    end else if (busy_r) begin
      if ((hit && cand < limit) ||
          (CW+1)'(base_r) + (CW+1)'(8) >= (CW+1)'(limit)) begin
        done = 1'b1;
        found = hit && (cand < limit);
        busy_nxt = 1'b0;
      end else begin
        base_nxt = base_r + CW'(8);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      base_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      base_r <= base_nxt;
    end
  end
endmodule
`default_nettype wire

>>> src/slab_object_allocator.sv
`default_nettype none
// Slab object allocator for one object cache. One request is in flight at a
// time: in_ch.ready is high only in the idle state and stays low from
// acceptance until the cycle after the result word has been taken. An
// allocate picks a slab, probes its bitmap a byte at a time on the shared
// bitmap scanner, sets the found bit and presents the result; the set step
// is skipped when no clear bit is found, and the scan too when no slab is
// available. A free checks, clears the bit, relinks the slab and may shrink;
// an ignored free goes straight to the result, which is held until taken.
// Slab lists are kept as per-slot order ranks.
module slab_object_allocator #(
  parameter int SLAB_SLOTS = soa_pkg::SLAB_SLOTS_DEF,
  parameter int OBJ_MAX    = soa_pkg::OBJ_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_data,
  soa_in_if.sink          in_ch,
  soa_out_if.source       out_ch
);
  import soa_pkg::*;
  localparam int SW = $clog2(SLAB_SLOTS);
  localparam int LW = $clog2(SLAB_SLOTS+1);
  localparam int IW = $clog2(OBJ_MAX);
  localparam int CW = $clog2(OBJ_MAX+1);

  // config
  logic [6:0] objs_r;
  logic [4:0] limit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      objs_r  <= 7'd64;
      limit_r <= 5'd16;
    end else if (cfg_we) begin
      if (cfg_index == CFG_OBJS) objs_r <= cfg_data;
      else limit_r <= cfg_data[4:0];
    end
  end
  logic [CW-1:0] n_eff;
  always_comb begin
    if (objs_r == 0) n_eff = CW'(1);
    else if (32'(objs_r) > OBJ_MAX) n_eff = CW'(OBJ_MAX);
    else n_eff = CW'(objs_r);
  end

  // per-slot state; list order as rank (0 = head)
  logic [OBJ_MAX-1:0] bm_r [SLAB_SLOTS];
  logic [CW-1:0]      cnt_r [SLAB_SLOTS];
  kind_t              kind_r [SLAB_SLOTS];
  logic [LW-1:0]      rank_r [SLAB_SLOTS];
  logic [LW-1:0]      plen_r, flen_r;
  logic               grew_r;
  logic [10:0]        used_r;
  logic [4:0]         total_r;

  fsm_t          st_r, st_nxt;
  logic [SW-1:0] sid_r;
  logic [5:0]    oix_r;
  logic [1:0]    status_r;
  logic [SW-1:0] aslab_r;
  logic [IW-1:0] aidx_r;
  logic [4:0]    rel_r;
  // original slab id kept full width to test slot range
  logic [3:0]    in_sid_full_r;

  // head lookups and lowest unused slot
  logic [SW-1:0] phead, fhead, unused;
  logic          has_unused;
  always_comb begin
    phead = '0; fhead = '0; unused = '0; has_unused = 1'b0;
    for (int k = SLAB_SLOTS-1; k >= 0; k--) begin
      if (kind_r[k] == KIND_PARTIAL && rank_r[k] == '0) phead = SW'(k);
      if (kind_r[k] == KIND_FREE && rank_r[k] == '0) fhead = SW'(k);
      if (kind_r[k] == KIND_UNUSED) begin
        unused = SW'(k);
        has_unused = 1'b1;
      end
    end
  end

  logic          sc_start, sc_done, sc_found;
  logic [IW-1:0] sc_idx;
  soa_bit_scan #(.OBJ_MAX(OBJ_MAX)) u_scan (
    .clk(clk), .rst_n(rst_n), .start(sc_start), .word(bm_r[sid_r]),
    .limit(n_eff), .done(sc_done), .found(sc_found), .index(sc_idx)
  );

  logic       fvalid;
  always_comb begin
    fvalid = (32'(in_sid_full_r) < SLAB_SLOTS) &&
             (kind_r[sid_r] == KIND_PARTIAL || kind_r[sid_r] == KIND_FULL) &&
             (32'(oix_r) < 32'(n_eff)) && (32'(oix_r) < OBJ_MAX) &&
             bm_r[sid_r][oix_r[IW-1:0]] && (cnt_r[sid_r] != '0);
  end

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.status = status_r;
  assign out_ch.alloc_slab = 4'(aslab_r);
  assign out_ch.alloc_index = 6'(aidx_r);
  assign out_ch.used_count = used_r;
  assign out_ch.slab_count = total_r;
  assign out_ch.slabs_released = rel_r;

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    sc_start = 1'b0;
    case (st_r)
      S_IDLE:   if (in_ch.valid) st_nxt = (in_ch.req_type == REQ_ALLOC) ? S_PICK : S_FCHK;
      S_PICK:   begin
        if (plen_r != 0 || flen_r != 0 || (total_r < limit_r && has_unused)) begin
          st_nxt = S_SCAN;
          sc_start = 1'b1;
        end else st_nxt = S_OUT;
      end
      S_SCAN:   if (sc_done) st_nxt = sc_found ? S_SET : S_OUT;
      S_SET:    st_nxt = S_OUT;
      S_FCHK:   st_nxt = fvalid ? S_FCLR : S_OUT;
      S_FCLR:   st_nxt = S_FLIST;
      S_FLIST:  st_nxt = (cnt_r[sid_r] == '0 && 32'(total_r) > 32'(flen_r) + 1)
                         ? S_SHRINK : S_OUT;
      S_SHRINK: st_nxt = S_OUT;
      S_OUT:    if (out_ch.ready) st_nxt = S_IDLE;
      default:  st_nxt = S_IDLE;
    endcase
  end

  // datapath: list insert at head bumps ranks; removal lowers ranks behind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLAB_SLOTS; k++) begin
        bm_r[k] <= '0; cnt_r[k] <= '0; kind_r[k] <= KIND_UNUSED; rank_r[k] <= '0;
      end
      plen_r <= '0; flen_r <= '0; grew_r <= 1'b0; used_r <= '0; total_r <= '0;
      status_r <= ST_DONE; aslab_r <= '0; aidx_r <= '0; rel_r <= '0;
      sid_r <= '0; oix_r <= '0; in_sid_full_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: if (in_ch.valid) begin
          in_sid_full_r <= in_ch.slab_id;
          sid_r <= SW'(in_ch.slab_id);
          oix_r <= in_ch.obj_index;
          status_r <= ST_DONE; aslab_r <= '0; aidx_r <= '0; rel_r <= '0;
        end
        S_PICK: begin
          if (plen_r != 0) sid_r <= phead;
          else if (flen_r != 0) begin
            sid_r <= fhead;
            for (int k = 0; k < SLAB_SLOTS; k++) begin
              if (kind_r[k] == KIND_FREE) rank_r[k] <= rank_r[k] - 1'b1;
              if (kind_r[k] == KIND_PARTIAL) rank_r[k] <= rank_r[k] + 1'b1;
            end
            kind_r[fhead] <= KIND_PARTIAL; rank_r[fhead] <= '0;
            flen_r <= flen_r - 1'b1; plen_r <= plen_r + 1'b1;
          end else if (total_r < limit_r && has_unused) begin
            sid_r <= unused;
            for (int k = 0; k < SLAB_SLOTS; k++)
              if (kind_r[k] == KIND_PARTIAL) rank_r[k] <= rank_r[k] + 1'b1;
            bm_r[unused] <= '0; cnt_r[unused] <= '0;
            kind_r[unused] <= KIND_PARTIAL; rank_r[unused] <= '0;
            plen_r <= plen_r + 1'b1; total_r <= total_r + 1'b1; grew_r <= 1'b1;
          end else status_r <= ST_NOSLAB;
        end
        S_SCAN: if (sc_done) begin
          if (sc_found) aidx_r <= sc_idx;
          else status_r <= ST_NOSLAB;
        end
        S_SET: begin
          bm_r[sid_r][aidx_r] <= 1'b1;
          cnt_r[sid_r] <= cnt_r[sid_r] + 1'b1;
          used_r <= used_r + 1'b1;
          aslab_r <= sid_r;
          if (cnt_r[sid_r] + 1'b1 >= n_eff) begin
            for (int k = 0; k < SLAB_SLOTS; k++)
              if (kind_r[k] == KIND_PARTIAL && rank_r[k] > rank_r[sid_r])
                rank_r[k] <= rank_r[k] - 1'b1;
            kind_r[sid_r] <= KIND_FULL;
            plen_r <= plen_r - 1'b1;
          end
        end
        S_FCHK: if (!fvalid) status_r <= ST_IGNORED;
        S_FCLR: begin
          bm_r[sid_r][oix_r[IW-1:0]] <= 1'b0;
          cnt_r[sid_r] <= cnt_r[sid_r] - 1'b1;
          if (used_r != 0) used_r <= used_r - 1'b1;
          if (kind_r[sid_r] == KIND_PARTIAL) begin
            for (int k = 0; k < SLAB_SLOTS; k++)
              if (kind_r[k] == KIND_PARTIAL && rank_r[k] > rank_r[sid_r])
                rank_r[k] <= rank_r[k] - 1'b1;
            plen_r <= plen_r - 1'b1;
          end
          kind_r[sid_r] <= KIND_FULL;
        end
        S_FLIST: begin
          if (cnt_r[sid_r] == '0) begin
            for (int k = 0; k < SLAB_SLOTS; k++)
              if (kind_r[k] == KIND_FREE) rank_r[k] <= rank_r[k] + 1'b1;
            kind_r[sid_r] <= KIND_FREE; rank_r[sid_r] <= '0;
            flen_r <= flen_r + 1'b1;
          end else begin
            for (int k = 0; k < SLAB_SLOTS; k++)
              if (kind_r[k] == KIND_PARTIAL) rank_r[k] <= rank_r[k] + 1'b1;
            kind_r[sid_r] <= KIND_PARTIAL; rank_r[sid_r] <= '0;
            plen_r <= plen_r + 1'b1;
          end
        end
        S_SHRINK: begin
          if (grew_r) grew_r <= 1'b0;
          else begin
            rel_r <= 5'(flen_r);
            total_r <= total_r - 5'(flen_r);
            for (int k = 0; k < SLAB_SLOTS; k++)
              if (kind_r[k] == KIND_FREE) begin
                kind_r[k] <= KIND_UNUSED; cnt_r[k] <= '0;
              end
            flen_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // list lengths never exceed the slab count
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    32'(plen_r) + 32'(flen_r) <= 32'(total_r)) else $error("list length overflow");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("ready during work");
  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
endmodule
`default_nettype wire
